// ----- src/modbus_request_framer_crc16_macros.svh -----
// Assertion macros shared by the request framer.
`ifndef MODBUS_REQUEST_FRAMER_CRC16_MACROS_SVH
`define MODBUS_REQUEST_FRAMER_CRC16_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MRF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/mrf_pkg.sv -----
// Types and constants of the Modbus RTU request framer.
package mrf_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] WORD_COUNT = 16'd2;
	localparam logic [7:0]  BYTE_COUNT = 8'(WORD_COUNT * 16'd2);

	localparam int IDX_W = 4;

	// Byte positions inside a frame.
	localparam logic [IDX_W-1:0] IDX_ID      = 4'd0;
	localparam logic [IDX_W-1:0] IDX_FC      = 4'd1;
	localparam logic [IDX_W-1:0] IDX_ADDR_HI = 4'd2;
	localparam logic [IDX_W-1:0] IDX_ADDR_LO = 4'd3;
	localparam logic [IDX_W-1:0] IDX_CNT_HI  = 4'd4;
	localparam logic [IDX_W-1:0] IDX_CNT_LO  = 4'd5;
	localparam logic [IDX_W-1:0] IDX_BYTES   = 4'd6;
	localparam logic [IDX_W-1:0] IDX_DATA3   = 4'd7;
	localparam logic [IDX_W-1:0] IDX_DATA2   = 4'd8;
	localparam logic [IDX_W-1:0] IDX_DATA1   = 4'd9;
	localparam logic [IDX_W-1:0] IDX_DATA0   = 4'd10;
	localparam logic [IDX_W-1:0] IDX_WR_CRC_LO = 4'd11;
	localparam logic [IDX_W-1:0] IDX_WR_CRC_HI = 4'd12;
	localparam logic [IDX_W-1:0] IDX_RD_CRC_LO = 4'd6;
	localparam logic [IDX_W-1:0] IDX_RD_CRC_HI = 4'd7;

	// Operation codes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Configuration register indexes (paddr bit 2).
	localparam logic REG_WRITE_FC = 1'b0;
	localparam logic REG_READ_FC  = 1'b1;

	typedef struct packed {
		logic       init;
		logic       upd;
		logic [7:0] data;
	} crc_ctl_t;

	typedef struct packed {
		logic             busy;
		logic [IDX_W-1:0] idx;
	} seq_status_t;

endpackage

// ----- src/modbus_request_framer_crc16.sv -----
// Top level of the Modbus RTU request framer with CRC-16.
// Usage:
// - The request channel (req_valid, req_stall) takes one item: operation,
//   slave_id, register_address and write_data. req_stall is high while a
//   frame is being produced.
// - The byte channel (tx_valid, tx_stall) gives one frame byte per item,
//   with last_byte set on the CRC high byte.
// - A write request gives 13 bytes, a read request 8 bytes. Once the request
//   is registered, one byte per cycle enters the output register unless the receiver stalls.
// - A new request is taken in the cycle the last byte enters the output
//   register, so back-to-back frames follow without a gap. The one CRC unit
//   folds one byte a cycle while body bytes enter the output register.
// - When the receiver stalls, the output register holds its byte and the
//   sequencer and CRC unit wait; no byte is lost.
// - Function codes sit in two APB registers (0x0 write, 0x4 read); the user
//   writes them only while no frame is in flight (the block does not enforce it).
// - Reset clears the frame in progress and the output valid, and sets the
//   function codes to 16 and 3.
module modbus_request_framer_crc16 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        operation,
	input  logic [7:0]  slave_id,
	input  logic [15:0] register_address,
	input  logic [31:0] write_data,
	output logic        tx_valid,
	input  logic        tx_stall,
	output logic [7:0]  tx_byte,
	output logic        last_byte
);
	import mrf_pkg::*;
	`include "modbus_request_framer_crc16_macros.svh"

	logic [7:0]  write_fc_q;
	logic [7:0]  read_fc_q;
	logic        reg_wr;
	logic [15:0] crc;
	crc_ctl_t    crc_ctl;
	seq_status_t st;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_fc_q <= 8'd16;
			read_fc_q  <= 8'd3;
		end else if (reg_wr) begin
			unique case (paddr[2])
				REG_WRITE_FC: write_fc_q <= pwdata[7:0];
				REG_READ_FC:  read_fc_q  <= pwdata[7:0];
				default:      write_fc_q <= write_fc_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WRITE_FC: prdata = {24'h000000, write_fc_q};
			REG_READ_FC:  prdata = {24'h000000, read_fc_q};
			default:      prdata = 32'h00000000;
		endcase
	end

	mrf_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.crc    (crc)
	);

	mrf_sequencer u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.operation        (operation),
		.slave_id         (slave_id),
		.register_address (register_address),
		.write_data       (write_data),
		.write_fc         (write_fc_q),
		.read_fc          (read_fc_q),
		.crc              (crc),
		.crc_ctl          (crc_ctl),
		.status           (st),
		.tx_valid         (tx_valid),
		.tx_stall         (tx_stall),
		.tx_byte          (tx_byte),
		.last_byte        (last_byte)
	);

	`MRF_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "request not held after accept")
	`MRF_ASSERT_IMPL(a_idx_range, st.busy, st.idx <= IDX_WR_CRC_HI, "byte index past end of frame")
	`MRF_ASSERT_NEXT(a_hold_on_stall, st.busy && tx_valid && tx_stall, $stable(st.idx), "sequencer advanced while output stalled")

endmodule

// ----- src/mrf_crc_unit.sv -----
// Shared CRC-16 unit: folds one frame byte per cycle, while upd is set, into the running checksum.
module mrf_crc_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  mrf_pkg::crc_ctl_t ctl,
	output logic [15:0]       crc
);
	import mrf_pkg::*;

	logic [15:0] crc_q;
	logic [15:0] crc_next;

	// Eight shift-and-reduce steps of the reflected polynomial.
	always_comb begin
		crc_next = crc_q ^ {8'h00, ctl.data};
		for (int k = 0; k < 8; k++) begin
			if (crc_next[0]) begin
				crc_next = (crc_next >> 1) ^ CRC_POLY;
			end else begin
				crc_next = crc_next >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.init) begin
			crc_q <= CRC_INIT;
		end else if (ctl.upd) begin
			crc_q <= crc_next;
		end
	end

	assign crc = crc_q;

endmodule

// ----- src/mrf_sequencer.sv -----
// Frame sequencer: holds one request, steps through its bytes and drives the output register.
module mrf_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 operation,
	input  logic [7:0]           slave_id,
	input  logic [15:0]          register_address,
	input  logic [31:0]          write_data,
	input  logic [7:0]           write_fc,
	input  logic [7:0]           read_fc,
	input  logic [15:0]          crc,
	output mrf_pkg::crc_ctl_t    crc_ctl,
	output mrf_pkg::seq_status_t status,
	output logic                 tx_valid,
	input  logic                 tx_stall,
	output logic [7:0]           tx_byte,
	output logic                 last_byte
);
	import mrf_pkg::*;

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic             op_q;
	logic [7:0]       id_q;
	logic [15:0]      addr_q;
	logic [31:0]      data_q;
	logic             tx_valid_q;
	logic [7:0]       tx_byte_q;
	logic             last_q;

	logic       load;
	logic       accept;
	logic       crc_lo;
	logic       crc_hi;
	logic [7:0] body_byte;
	logic [7:0] sel_byte;

	assign crc_lo = (op_q == OP_READ) ? (idx_q == IDX_RD_CRC_LO) : (idx_q == IDX_WR_CRC_LO);
	assign crc_hi = (op_q == OP_READ) ? (idx_q == IDX_RD_CRC_HI) : (idx_q == IDX_WR_CRC_HI);

	// While a frame is in flight, a byte moves into the output register whenever that register is free or drains.
	assign load      = busy_q && (!tx_valid_q || !tx_stall);
	assign req_stall = busy_q && !(load && crc_hi);
	assign accept    = req_valid && !req_stall;

	always_comb begin
		unique case (idx_q)
			IDX_ID:      body_byte = id_q;
			IDX_FC:      body_byte = (op_q == OP_READ) ? read_fc : write_fc;
			IDX_ADDR_HI: body_byte = addr_q[15:8];
			IDX_ADDR_LO: body_byte = addr_q[7:0];
			IDX_CNT_HI:  body_byte = WORD_COUNT[15:8];
			IDX_CNT_LO:  body_byte = WORD_COUNT[7:0];
			IDX_BYTES:   body_byte = BYTE_COUNT;
			IDX_DATA3:   body_byte = data_q[31:24];
			IDX_DATA2:   body_byte = data_q[23:16];
			IDX_DATA1:   body_byte = data_q[15:8];
			IDX_DATA0:   body_byte = data_q[7:0];
			default:     body_byte = 8'h00;
		endcase
	end

	always_comb begin
		priority if (crc_lo) begin
			sel_byte = crc[7:0];
		end else if (crc_hi) begin
			sel_byte = crc[15:8];
		end else begin
			sel_byte = body_byte;
		end
	end

	assign crc_ctl.init = accept;
	assign crc_ctl.upd  = load && !crc_lo && !crc_hi;
	assign crc_ctl.data = body_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			idx_q  <= IDX_ID;
		end else if (load) begin
			busy_q <= !crc_hi;
			idx_q  <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			id_q   <= slave_id;
			addr_q <= register_address;
			data_q <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid_q <= 1'b0;
		end else if (load) begin
			tx_valid_q <= 1'b1;
		end else if (!tx_stall) begin
			tx_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tx_byte_q <= sel_byte;
			last_q    <= crc_hi;
		end
	end

	assign tx_valid      = tx_valid_q;
	assign tx_byte       = tx_byte_q;
	assign last_byte     = last_q;
	assign status.busy   = busy_q;
	assign status.idx    = idx_q;

endmodule

// ----- tb/modbus_request_framer_crc16_checker.sv -----
// Frame predictor and byte checker for the Modbus RTU request framer.
module modbus_request_framer_crc16_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic        operation,
	input  logic [7:0]  slave_id,
	input  logic [15:0] register_address,
	input  logic [31:0] write_data,
	input  logic        tx_valid,
	input  logic        tx_stall,
	input  logic [7:0]  tx_byte,
	input  logic        last_byte,
	output int          errors,
	output int          pending
);
	import mrf_pkg::*;

	localparam logic [7:0] WRITE_FC_RESET = 8'd16;
	localparam logic [7:0] READ_FC_RESET  = 8'd3;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} frame_byte_t;

	frame_byte_t frame_q[$];
	logic [7:0]  write_fc;
	logic [7:0]  read_fc;

	function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// Builds the whole request frame of one item and queues its bytes.
	task automatic queue_frame(input logic op, input logic [7:0] id, input logic [15:0] addr,
			input logic [31:0] data);
		logic [7:0]  bytes [13];
		logic [15:0] crc;
		int          n;
		bytes[0] = id;
		bytes[1] = (op == OP_READ) ? read_fc : write_fc;
		bytes[2] = addr[15:8];
		bytes[3] = addr[7:0];
		bytes[4] = WORD_COUNT[15:8];
		bytes[5] = WORD_COUNT[7:0];
		n = 6;
		if (op == OP_WRITE) begin
			bytes[6] = BYTE_COUNT;
			bytes[7] = data[31:24];
			bytes[8] = data[23:16];
			bytes[9] = data[15:8];
			bytes[10] = data[7:0];
			n = 11;
		end
		crc = CRC_INIT;
		for (int i = 0; i < n; i++)
			crc = crc16_fold(crc, bytes[i]);
		bytes[n] = crc[7:0];
		bytes[n + 1] = crc[15:8];
		for (int i = 0; i < n + 2; i++)
			frame_q.push_back(frame_byte_t'{bytes[i], (i == n + 1)});
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		frame_byte_t want;
		if (!arst_n) begin
			write_fc = WRITE_FC_RESET;
			read_fc = READ_FC_RESET;
			frame_q.delete();
			pending = 0;
		end else begin
			// Bytes are checked before new requests are queued, since a frame
			// never starts at the edge its request is taken.
			if (tx_valid && !tx_stall) begin
				if (frame_q.size() == 0) begin
					$error("tx_byte: unexpected item 0x%02h, no byte expected", tx_byte);
					errors++;
				end else begin
					want = frame_q.pop_front();
					if (tx_byte !== want.value) begin
						$error("tx_byte: expected 0x%02h, got 0x%02h", want.value, tx_byte);
						errors++;
					end
					if (last_byte !== want.last) begin
						$error("last_byte: expected %0b, got %0b", want.last, last_byte);
						errors++;
					end
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[2])
						REG_WRITE_FC: write_fc = pwdata[7:0];
						REG_READ_FC:  read_fc = pwdata[7:0];
					endcase
				end else begin
					want.value = (paddr[2] == REG_READ_FC) ? read_fc : write_fc;
					if (prdata[7:0] !== want.value) begin
						$error("prdata: expected 0x%02h, got 0x%02h", want.value, prdata[7:0]);
						errors++;
					end
				end
			end
			if (req_valid && !req_stall)
				queue_frame(operation, slave_id, register_address, write_data);
			pending = frame_q.size();
		end
	end

endmodule

// ----- tb/tb_modbus_request_framer_crc16.sv -----
// Testbench top for the Modbus RTU request framer: stimulus, stalls and verdict.
module tb_modbus_request_framer_crc16;
	import mrf_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 460;
	localparam int PHASES = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        operation = OP_WRITE;
	logic [7:0]  slave_id = '0;
	logic [15:0] register_address = '0;
	logic [31:0] write_data = '0;
	logic        tx_valid;
	logic        tx_stall = 1'b0;
	logic [7:0]  tx_byte;
	logic        last_byte;

	int errors;
	int pending;
	int cycle_cnt = 0;
	bit hurry = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	modbus_request_framer_crc16 dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall), .operation(operation),
		.slave_id(slave_id), .register_address(register_address), .write_data(write_data),
		.tx_valid(tx_valid), .tx_stall(tx_stall), .tx_byte(tx_byte), .last_byte(last_byte)
	);

	modbus_request_framer_crc16_checker frame_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall), .operation(operation),
		.slave_id(slave_id), .register_address(register_address), .write_data(write_data),
		.tx_valid(tx_valid), .tx_stall(tx_stall), .tx_byte(tx_byte), .last_byte(last_byte),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Byte receiver: stalls a random number of cycles before each item.
	initial begin
		int n;
		@(posedge clk);
		forever begin
			n = hurry ? 0 : $urandom_range(0, 9);
			if (n > 0) begin
				tx_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			tx_stall <= 1'b0;
			do @(posedge clk); while (!tx_valid);
		end
	end

	// Mostly random values, with all-zeros and all-ones mixed in.
	function automatic logic [31:0] pick_value(input int bits);
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			default: v = $urandom;
		endcase
		return (bits == 32) ? v : (v & ((32'd1 << bits) - 1));
	endfunction

	task automatic send_request(input logic op, input logic [7:0] id, input logic [15:0] addr,
			input logic [31:0] data);
		int gap;
		gap = hurry ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		slave_id <= id;
		register_address <= addr;
		write_data <= data;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Upper pwdata bits are random to show that only the low byte is kept.
	task automatic set_codes(input logic [7:0] wr_fc, input logic [7:0] rd_fc);
		apb_access(1'b1, REG_WRITE_FC, {24'($urandom_range(0, 32'hFFFFFF)), wr_fc});
		apb_access(1'b1, REG_READ_FC, {24'($urandom_range(0, 32'hFFFFFF)), rd_fc});
		apb_access(1'b0, REG_WRITE_FC, '0);
		apb_access(1'b0, REG_READ_FC, '0);
	endtask

	initial begin
		logic [7:0] wr_fc;
		logic [7:0] rd_fc;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset function codes.
		send_request(OP_WRITE, 8'h00, 16'h0000, 32'h0000_0000);
		send_request(OP_WRITE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(OP_READ, 8'h00, 16'h0000, 32'h0000_0000);
		send_request(OP_READ, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(OP_READ, 8'h11, 16'h006B, 32'hDEAD_BEEF);
		send_request(OP_READ, 8'h11, 16'h006B, 32'h0000_0000);
		send_request(OP_WRITE, 8'h00, 16'h1234, 32'h0102_0304);
		send_request(OP_READ, 8'h00, 16'h1234, 32'h0000_0000);
		send_request(OP_WRITE, 8'hAA, 16'hAAAA, 32'hAAAA_AAAA);
		send_request(OP_WRITE, 8'h55, 16'h5555, 32'h5555_5555);
		send_request(OP_WRITE, 8'hA5, 16'h5A5A, 32'hA5A5_5A5A);
		send_request(OP_READ, 8'h5A, 16'hA5A5, 32'h5A5A_A5A5);
		send_request(OP_WRITE, 8'h01, 16'h8000, 32'h8000_0001);
		send_request(OP_READ, 8'h80, 16'h0001, 32'h7FFF_FFFE);
		send_request(OP_WRITE, 8'hF7, 16'h0000, 32'hFFFF_0000);
		send_request(OP_WRITE, 8'h01, 16'hFFFF, 32'h0000_FFFF);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin wr_fc = 8'h00; rd_fc = 8'hFF; end
				1: begin wr_fc = 8'hFF; rd_fc = 8'h00; end
				default: begin wr_fc = 8'(pick_value(8)); rd_fc = 8'(pick_value(8)); end
			endcase
			set_codes(wr_fc, rd_fc);
			// One phase runs with neither side idling.
			hurry = (p == 3);
			for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
				send_request(1'($urandom_range(0, 1)), 8'(pick_value(8)),
					16'(pick_value(16)), pick_value(32));
			wait_idle();
			hurry = 1'b0;
		end

		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
